>>> rtl/bst_pkg.sv
package bst_pkg;

    localparam int SETTING_WIDTH_DEF = 16;
    localparam int CFG_DATA_WIDTH    = 16;
    localparam int CFG_INDEX_WIDTH   = 3;

    localparam int MIN_SETTING_RST   = 50;
    localparam int MAX_SETTING_RST   = 5000;
    localparam int SLOW_WAIT_RST     = 200;
    localparam int MEDIUM_WAIT_RST   = 100;
    localparam int FAST_WAIT_RST     = 10;
    localparam int SLOW_STEPS_RST    = 10;
    localparam int MEDIUM_STEPS_RST  = 50;
    localparam int MESSAGE_TICKS_RST = 500;
    localparam int DURATION_RST      = 500;
    localparam int IDLE_POLL         = 100;
    localparam int CONFIRM_POLL      = 50;

    typedef enum logic [2:0]
    {
        PH_IDLE    = 3'd0,
        PH_UP      = 3'd1,
        PH_DOWN    = 3'd2,
        PH_CONFIRM = 3'd3,
        PH_RUN     = 3'd4,
        PH_FIN     = 3'd5,
        PH_CANCEL  = 3'd6
    } phase_t;

    typedef enum logic [2:0]
    {
        REG_MIN_SETTING   = 3'd0,
        REG_MAX_SETTING   = 3'd1,
        REG_SLOW_WAIT     = 3'd2,
        REG_MEDIUM_WAIT   = 3'd3,
        REG_FAST_WAIT     = 3'd4,
        REG_SLOW_STEPS    = 3'd5,
        REG_MEDIUM_STEPS  = 3'd6,
        REG_MESSAGE_TICKS = 3'd7
    } cfg_index_t;

    typedef struct packed
    {
        logic [15:0] min_setting;
        logic [15:0] max_setting;
        logic [9:0]  slow_wait;
        logic [9:0]  medium_wait;
        logic [9:0]  fast_wait;
        logic [7:0]  slow_steps;
        logic [7:0]  medium_steps;
        logic [11:0] message_ticks;
    } cfg_t;

    typedef struct packed
    {
        logic up;
        logic down;
        logic start;
    } buttons_t;

    typedef struct packed
    {
        logic        pulse_out;
        logic [15:0] setting;
        logic [2:0]  phase;
    } result_t;

endpackage

>>> rtl/button_set_one_shot_timer.sv
// channel   dir  handshake              payload
// cfg       in   cfg_we                 cfg_index, cfg_data
// in        in   in_valid / in_stall    btn_up, btn_down, btn_start
// out       out  out_valid / out_stall  pulse_out, setting, phase
//
// One tick word per cycle while in_stall is low; its result word is registered
// in the output buffer, and the core updates its state once per accepted tick.
// rst_n clears the settings to defaults and the timer to idle, wait counter at 100.
// A two-word output buffer lets a tick be taken while a result is stalled;
// in_stall rises only once both words are held.
module button_set_one_shot_timer
    import bst_pkg::*;
#(
    parameter int SETTING_WIDTH = SETTING_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       btn_up,
    input  logic                       btn_down,
    input  logic                       btn_start,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       pulse_out,
    output logic [15:0]                setting,
    output logic [2:0]                 phase
);

    cfg_t     cfg;
    buttons_t btn;
    result_t  core_word;
    result_t  out_word;
    logic     advance;

    assign btn.up    = btn_up;
    assign btn.down  = btn_down;
    assign btn.start = btn_start;
    assign advance   = in_valid && !in_stall;

    bst_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bst_core #(.SETTING_WIDTH(SETTING_WIDTH)) u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .btn     (btn),
        .result  (core_word)
    );

    bst_skid u_skid
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_stall (in_stall),
        .push_word  (core_word),
        .pop_valid  (out_valid),
        .pop_stall  (out_stall),
        .pop_word   (out_word)
    );

    assign pulse_out = out_word.pulse_out;
    assign setting   = out_word.setting;
    assign phase     = out_word.phase;

endmodule

>>> rtl/bst_cfg.sv
module bst_cfg
    import bst_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_MIN_SETTING:   cfg_next.min_setting   = cfg_data;
                REG_MAX_SETTING:   cfg_next.max_setting   = cfg_data;
                REG_SLOW_WAIT:     cfg_next.slow_wait     = cfg_data[9:0];
                REG_MEDIUM_WAIT:   cfg_next.medium_wait   = cfg_data[9:0];
                REG_FAST_WAIT:     cfg_next.fast_wait     = cfg_data[9:0];
                REG_SLOW_STEPS:    cfg_next.slow_steps    = cfg_data[7:0];
                REG_MEDIUM_STEPS:  cfg_next.medium_steps  = cfg_data[7:0];
                REG_MESSAGE_TICKS: cfg_next.message_ticks = cfg_data[11:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_setting   <= 16'(MIN_SETTING_RST);
            cfg_reg.max_setting   <= 16'(MAX_SETTING_RST);
            cfg_reg.slow_wait     <= 10'(SLOW_WAIT_RST);
            cfg_reg.medium_wait   <= 10'(MEDIUM_WAIT_RST);
            cfg_reg.fast_wait     <= 10'(FAST_WAIT_RST);
            cfg_reg.slow_steps    <= 8'(SLOW_STEPS_RST);
            cfg_reg.medium_steps  <= 8'(MEDIUM_STEPS_RST);
            cfg_reg.message_ticks <= 12'(MESSAGE_TICKS_RST);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/bst_core.sv
module bst_core
    import bst_pkg::*;
#(
    parameter int SETTING_WIDTH = SETTING_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     advance,
    input  buttons_t btn,
    output result_t  result
);

    localparam int SW = SETTING_WIDTH;
    localparam int WW = (SW > 12) ? SW : 12;
    localparam int CW = (SW > 16) ? SW : 16;
    localparam logic [31:0] DUR_RST_W = 32'(DURATION_RST);

    typedef struct packed
    {
        logic [7:0] rep;
        logic [9:0] wait_val;
    } step_t;

    function automatic step_t step_calc(input logic [7:0] rep, input cfg_t c);
        step_t      s;
        logic [9:0] w;
        if (rep < c.slow_steps)
            w = c.slow_wait;
        else if (rep < c.medium_steps)
            w = c.medium_wait;
        else
            w = c.fast_wait;
        if (((rep < c.slow_steps) || (rep < c.medium_steps)) && (rep != 8'hFF))
            s.rep = rep + 8'd1;
        else
            s.rep = rep;
        s.wait_val = (w == 10'd0) ? 10'd1 : w;
        return s;
    endfunction

    phase_t          phase_reg, phase_next;
    logic [SW-1:0]   duration_reg, duration_next;
    logic [WW-1:0]   wait_reg, wait_next;
    logic [7:0]      repeat_reg, repeat_next;
    logic [1:0]      checks_reg, checks_next;

    logic            can_inc;
    logic            can_dec;
    logic            expired;
    step_t           cont_step;
    step_t           new_step;
    logic [1:0]      stage_sel;
    logic            do_poll;
    logic            msg_req;
    phase_t          msg_phase;
    logic            go_idle;
    logic [CW-1:0]   dur_ext;

    assign can_inc   = (CW'(duration_reg) < CW'(cfg.max_setting)) && (duration_reg != '1);
    assign can_dec   = CW'(duration_reg) > CW'(cfg.min_setting);
    assign expired   = wait_reg <= WW'(1);
    assign cont_step = step_calc(repeat_reg, cfg);
    assign new_step  = step_calc(8'd0, cfg);
    assign stage_sel = ((phase_reg == PH_UP) || (phase_reg == PH_DOWN))
                       ? (2'd3 - checks_reg) : 2'd0;

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        duration_next = duration_reg;
        wait_next     = wait_reg;
        repeat_next   = repeat_reg;
        checks_next   = checks_reg;
        do_poll       = 1'b0;
        msg_req       = 1'b0;
        msg_phase     = PH_FIN;
        go_idle       = 1'b0;

        if (!expired)
        begin
            wait_next = wait_reg - WW'(1);
        end
        else
        begin
            case (phase_reg)
                PH_UP:
                begin
                    if (btn.up && can_inc)
                    begin
                        duration_next = duration_reg + SW'(1);
                        repeat_next   = cont_step.rep;
                        wait_next     = WW'(cont_step.wait_val);
                    end
                    else
                    begin
                        do_poll = 1'b1;
                    end
                end
                PH_DOWN:
                begin
                    if (btn.down && can_dec)
                    begin
                        duration_next = duration_reg - SW'(1);
                        repeat_next   = cont_step.rep;
                        wait_next     = WW'(cont_step.wait_val);
                    end
                    else
                    begin
                        do_poll = 1'b1;
                    end
                end
                PH_CONFIRM:
                begin
                    if (btn.down)
                    begin
                        if (duration_reg == '0)
                        begin
                            msg_req   = 1'b1;
                            msg_phase = PH_FIN;
                        end
                        else
                        begin
                            phase_next = PH_RUN;
                            wait_next  = WW'(duration_reg);
                        end
                    end
                    else if (btn.up)
                    begin
                        msg_req   = 1'b1;
                        msg_phase = PH_CANCEL;
                    end
                    else
                    begin
                        wait_next = WW'(CONFIRM_POLL);
                    end
                end
                PH_RUN:
                begin
                    msg_req   = 1'b1;
                    msg_phase = PH_FIN;
                end
                PH_FIN, PH_CANCEL:
                begin
                    go_idle = 1'b1;
                end
                default:
                begin
                    do_poll = 1'b1;
                end
            endcase
        end

        if (msg_req)
        begin
            if (cfg.message_ticks == 12'd0)
            begin
                go_idle = 1'b1;
            end
            else
            begin
                phase_next = msg_phase;
                wait_next  = WW'(cfg.message_ticks);
            end
        end

        // poll order: up, down, start
        if (do_poll)
        begin
            if ((stage_sel == 2'd0) && btn.up && can_inc)
            begin
                phase_next    = PH_UP;
                checks_next   = 2'd2;
                duration_next = duration_reg + SW'(1);
                repeat_next   = new_step.rep;
                wait_next     = WW'(new_step.wait_val);
            end
            else if ((stage_sel <= 2'd1) && btn.down && can_dec)
            begin
                phase_next    = PH_DOWN;
                checks_next   = 2'd1;
                duration_next = duration_reg - SW'(1);
                repeat_next   = new_step.rep;
                wait_next     = WW'(new_step.wait_val);
            end
            else if ((stage_sel <= 2'd2) && btn.start)
            begin
                phase_next  = PH_CONFIRM;
                checks_next = 2'd0;
                wait_next   = WW'(CONFIRM_POLL);
            end
            else
            begin
                go_idle = 1'b1;
            end
        end

        if (go_idle)
        begin
            phase_next  = PH_IDLE;
            wait_next   = WW'(IDLE_POLL);
            checks_next = 2'd0;
        end
    end

    // result word
    always_comb
    begin
        dur_ext          = CW'(duration_next);
        result.pulse_out = (phase_next == PH_RUN);
        result.setting   = dur_ext[15:0];
        if (phase_next inside {[PH_IDLE:PH_CANCEL]})
            result.phase = phase_next;
        else
            result.phase = PH_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            duration_reg <= DUR_RST_W[SW-1:0];
            wait_reg     <= WW'(IDLE_POLL);
            repeat_reg   <= 8'd0;
            checks_reg   <= 2'd0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            duration_reg <= duration_next;
            wait_reg     <= wait_next;
            repeat_reg   <= repeat_next;
            checks_reg   <= checks_next;
        end
    end

endmodule

>>> rtl/bst_skid.sv
module bst_skid
    import bst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_stall,
    input  result_t push_word,
    output logic    pop_valid,
    input  logic    pop_stall,
    output result_t pop_word
);

    logic    out_valid_reg;
    result_t out_word_reg;
    logic    skid_valid_reg;
    result_t skid_word_reg;
    logic    push;
    logic    pop;

    assign push_stall = skid_valid_reg;
    assign push       = push_valid && !skid_valid_reg;
    assign pop        = out_valid_reg && !pop_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_word_reg <= skid_word_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_word_reg <= push_word;
            else
                skid_word_reg <= push_word;
        end
    end

    assign pop_valid = out_valid_reg;
    assign pop_word  = out_word_reg;

endmodule

>>> rtl/bst_checker.sv
module bst_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        pulse_out,
    input logic [15:0] setting,
    input logic [2:0]  phase
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pulse_out) && $stable(setting) && $stable(phase))
        else $error("stalled result word changed");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
        else $error("input stalled without a stalled result");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted tick produced no result word");

endmodule

bind button_set_one_shot_timer bst_checker u_bst_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pulse_out (pulse_out),
    .setting   (setting),
    .phase     (phase)
);
